// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Each use names the clock and the active-low reset of the block it watches.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants of the bracket balance checker: scan modes, status
// codes, character codes and the stack command and status words.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    localparam int MAX_NESTING = 32;
    localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
    localparam int STK_AW      = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4,
        MODE_QUOTE      = 3'd5,
        MODE_QUOTE_ESC  = 3'd6
    } t_scan_mode;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_MISSING_CLOSER = 3'd1,
        ST_MISSING_QUOTE  = 3'd2,
        ST_UNEXPECTED     = 3'd3,
        ST_OPEN_COMMENT   = 3'd4,
        ST_OVERFLOW       = 3'd5
    } t_status;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic paren;
    } t_stk_cmd;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               top_paren;
    } t_stk_stat;

endpackage

`default_nettype wire

// ===== rtl/bbc_stack.sv =====
// ----------------------------------------------------------------------------
// bbc_stack
// Stack of expected closers. The top entry lives in a register; the entries
// below it live in a one-port-write, one-port-read synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbc_pkg::t_stk_cmd  i_cmd,
    output bbc_pkg::t_stk_stat o_stat
);
    import bbc_pkg::*;

    logic               r_mem [MAX_NESTING];
    logic               r_rd;
    logic               r_fwd;
    logic               r_fwd_bit;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_top;

    logic [DEPTH_W-1:0] n_depth;
    logic               n_top;
    logic [DEPTH_W-1:0] wr_full;
    logic [DEPTH_W-1:0] rd_full;
    logic [STK_AW-1:0]  wr_addr;
    logic [STK_AW-1:0]  rd_addr;
    logic               wr_en;
    logic               below;

    // The read always targets the entry just below the next top, so a pop in
    // the following cycle finds it waiting. A write to that same entry in this
    // cycle is forwarded around the memory.
    assign below   = r_fwd ? r_fwd_bit : r_rd;
    assign wr_en   = i_cmd.push && (r_depth != '0);
    assign wr_full = r_depth - DEPTH_W'(1);
    assign rd_full = n_depth - DEPTH_W'(2);
    assign wr_addr = wr_full[STK_AW-1:0];
    assign rd_addr = rd_full[STK_AW-1:0];

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        if (i_cmd.clear) begin
            n_depth = '0;
        end else if (i_cmd.push) begin
            n_depth = r_depth + DEPTH_W'(1);
            n_top   = i_cmd.paren;
        end else if (i_cmd.pop) begin
            n_depth = r_depth - DEPTH_W'(1);
            n_top   = below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_top;
        end
        r_rd      <= r_mem[rd_addr];
        r_fwd_bit <= r_top;
        r_top     <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_fwd   <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign o_stat.depth     = r_depth;
    assign o_stat.top_paren = r_top;

endmodule

`default_nettype wire

// ===== rtl/code_bracket_balance_checker_top.sv =====
// ----------------------------------------------------------------------------
// code_bracket_balance_checker_top
// Scans C source text a byte at a time and reports bracket nesting, quote
// and comment errors when the terminating zero byte arrives.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_stall | i_text_byte
//  out      | output    | o_out_valid/i_out_stall | o_check_status, o_culprit_char
//
// One byte is taken per cycle while not stalled; the scan state and stack
// top update in the cycle of acceptance, and the stack memory read for a
// later pop is issued in the same cycle. A result follows in the cycle after
// its zero byte. Input stalls only while a result waits on a stalled output.
// Reset is synchronous and active low; the stack needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module code_bracket_balance_checker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_check_status,
    output logic [7:0] o_culprit_char
);
    import bbc_pkg::*;

    t_scan_mode r_mode;
    t_scan_mode n_mode;
    logic       r_quote_dq;
    logic       n_quote_dq;
    t_status    r_err_status;
    t_status    n_err_status;
    logic [7:0] r_err_char;
    logic [7:0] n_err_char;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [2:0] r_status;
    logic [2:0] n_status;
    logic [7:0] r_culprit;
    logic [7:0] n_culprit;

    t_stk_cmd   stk_cmd;
    t_stk_stat  stk_stat;

    logic       accept;
    logic       acc_end;
    logic       live;
    logic       as_code;
    logic       stk_full;
    logic       top_is_paren;
    logic [7:0] quote_char;
    logic [7:0] b;

    function automatic t_scan_mode code_mode(input logic [7:0] ch);
        t_scan_mode m;
        m = MODE_NORMAL;
        if (ch == CH_SLASH) begin
            m = MODE_SLASH;
        end else if (ch == CH_HASH) begin
            m = MODE_LINE;
        end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
            m = MODE_QUOTE;
        end
        return m;
    endfunction

    assign b            = i_text_byte;
    assign o_in_stall   = r_out_valid && i_out_stall;
    assign accept       = i_in_valid && !o_in_stall;
    assign acc_end      = accept && (b == CH_NUL);
    assign live         = accept && (b != CH_NUL) && (r_err_status == ST_OK);
    assign stk_full     = stk_stat.depth >= DEPTH_W'(MAX_NESTING);
    assign top_is_paren = (stk_stat.depth != '0) && stk_stat.top_paren;
    assign quote_char   = r_quote_dq ? CH_DQUOTE : CH_SQUOTE;

    // A slash that does not open a comment lets the following byte be code.
    assign as_code = (r_mode == MODE_NORMAL) ||
                     ((r_mode == MODE_SLASH) && (b != CH_SLASH) && (b != CH_STAR));

    // Next scan mode.
    always_comb begin
        n_mode     = r_mode;
        n_quote_dq = r_quote_dq;
        if (acc_end) begin
            n_mode     = MODE_NORMAL;
            n_quote_dq = 1'b0;
        end else if (live) begin
            unique case (r_mode)
                MODE_NORMAL: begin
                    n_mode = code_mode(b);
                end
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else if (b == CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end else begin
                        n_mode = code_mode(b);
                    end
                end
                MODE_LINE: begin
                    if (b == CH_NL) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_BLOCK: begin
                    if (b == CH_STAR) begin
                        n_mode = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR: begin
                    if (b == CH_SLASH) begin
                        n_mode = MODE_NORMAL;
                    end else if (b != CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end
                end
                MODE_QUOTE: begin
                    if (b == CH_BSLASH) begin
                        n_mode = MODE_QUOTE_ESC;
                    end else if (b == quote_char) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_QUOTE_ESC: begin
                    n_mode = MODE_QUOTE;
                end
                default: begin
                    n_mode = MODE_NORMAL;
                end
            endcase
            if (as_code && (b == CH_DQUOTE || b == CH_SQUOTE)) begin
                n_quote_dq = (b == CH_DQUOTE);
            end
        end
    end

    // Stack commands and error capture.
    always_comb begin
        stk_cmd       = '0;
        stk_cmd.clear = acc_end;
        n_err_status  = r_err_status;
        n_err_char    = r_err_char;
        if (acc_end) begin
            n_err_status = ST_OK;
            n_err_char   = CH_NUL;
        end else if (live && as_code) begin
            priority if (b == CH_LBRACE) begin
                if (top_is_paren) begin
                    n_err_status = ST_UNEXPECTED;
                    n_err_char   = b;
                end else if (stk_full) begin
                    n_err_status = ST_OVERFLOW;
                    n_err_char   = b;
                end else begin
                    stk_cmd.push  = 1'b1;
                    stk_cmd.paren = 1'b0;
                end
            end else if (b == CH_LPAREN) begin
                if (stk_full) begin
                    n_err_status = ST_OVERFLOW;
                    n_err_char   = b;
                end else begin
                    stk_cmd.push  = 1'b1;
                    stk_cmd.paren = 1'b1;
                end
            end else if (b == CH_RBRACE || b == CH_RPAREN) begin
                if ((stk_stat.depth != '0) && (stk_stat.top_paren == (b == CH_RPAREN))) begin
                    stk_cmd.pop = 1'b1;
                end else begin
                    n_err_status = ST_UNEXPECTED;
                    n_err_char   = b;
                end
            end else begin
                n_err_status = r_err_status;
            end
        end
    end

    // Result for the zero byte.
    always_comb begin
        n_status  = r_status;
        n_culprit = r_culprit;
        if (acc_end) begin
            if (r_err_status != ST_OK) begin
                n_status  = r_err_status;
                n_culprit = r_err_char;
            end else if (r_mode == MODE_BLOCK || r_mode == MODE_BLOCK_STAR) begin
                n_status  = ST_OPEN_COMMENT;
                n_culprit = CH_SLASH;
            end else if (r_mode == MODE_QUOTE || r_mode == MODE_QUOTE_ESC) begin
                n_status  = ST_MISSING_QUOTE;
                n_culprit = quote_char;
            end else if (stk_stat.depth != '0) begin
                n_status  = ST_MISSING_CLOSER;
                n_culprit = stk_stat.top_paren ? CH_RPAREN : CH_RBRACE;
            end else begin
                n_status  = ST_OK;
                n_culprit = CH_NUL;
            end
        end
    end

    assign n_out_valid = acc_end || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_quote_dq   <= 1'b0;
            r_err_status <= ST_OK;
            r_err_char   <= CH_NUL;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_quote_dq   <= n_quote_dq;
            r_err_status <= n_err_status;
            r_err_char   <= n_err_char;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_culprit <= n_culprit;
    end

    bbc_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    assign o_out_valid    = r_out_valid;
    assign o_check_status = r_status;
    assign o_culprit_char = r_culprit;

endmodule

`default_nettype wire

// ===== rtl/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks of the bracket balance checker, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_text_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_check_status,
    input logic [7:0] o_culprit_char
);
    import bbc_pkg::*;

    logic out_held;
    logic in_end;
    logic ok_clean;
    logic st_legal;

    assign out_held = o_out_valid && i_out_stall;
    assign in_end   = i_in_valid && !o_in_stall && (i_text_byte == CH_NUL);
    assign ok_clean = !o_out_valid || (o_check_status != ST_OK) || (o_culprit_char == CH_NUL);
    assign st_legal = !o_out_valid || (o_check_status <= ST_OVERFLOW);

    // A result that is not taken stays offered.
    `BBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid, "result dropped")

    // Every accepted zero byte yields a result in the next cycle.
    `BBC_ASSERT_NEXT(a_end_result, i_clk, i_rst_n, in_end, o_out_valid, "no result after end")

    // Input back-pressure only comes from a waiting result.
    `BBC_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_stall || out_held, "input stall without cause")

    // A clean text names no character.
    `BBC_ASSERT(a_ok_char, i_clk, i_rst_n, ok_clean, "ok status with a culprit")

    // Status codes stay within the defined set.
    `BBC_ASSERT(a_status_range, i_clk, i_rst_n, st_legal, "status out of range")

endmodule

bind code_bracket_balance_checker_top bbc_checker u_bbc_checker (.*);

`default_nettype wire
